>>> rtl/sfp_pkg.sv
// Shared types, codes and constants of the sensor frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

   localparam int SFP_MAX_FRAME_BYTES = 128;

   localparam logic [7:0] SIGNATURE_BYTE = 8'h0B;
   localparam logic [7:0] ESC_RAW_BYTE   = 8'h7E;
   localparam logic [7:0] ESC_XOR_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_FLIP_MASK  = 8'h20;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_SIGNATURE_OFFSET   = 3'd0,
      CSR_NODE_OFFSET        = 3'd1,
      CSR_BATTERY_OFFSET     = 3'd2,
      CSR_TEMPERATURE_OFFSET = 3'd3,
      CSR_LIGHT_OFFSET       = 3'd4,
      CSR_SENSOR_COUNT       = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_UPDATE   = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [8:0] {
      PH_START   = 9'b000000001,
      PH_TYPE    = 9'b000000010,
      PH_DEST    = 9'b000000100,
      PH_AMTYPE  = 9'b000001000,
      PH_AMGROUP = 9'b000010000,
      PH_LENGTH  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CRC     = 9'b010000000,
      PH_END     = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_RAW  = 2'd1,
      ESC_XOR  = 2'd2
   } escape_type;

   typedef struct packed {
      logic [6:0]  signature_offset;
      logic [6:0]  node_field_pos;
      logic [6:0]  battery_offset;
      logic [6:0]  temp_field_pos;
      logic [6:0]  light_field_pos;
      logic [15:0] sensor_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] node_id;
      logic [15:0] battery;
      logic [15:0] temperature;
      logic [15:0] light;
   } result_type;

   // place a byte into a little-endian 16-bit field at the given frame offset
   function automatic logic [15:0] put_le(input logic [15:0] value, input logic [6:0] off,
                                          input logic [7:0] pos, input logic [7:0] b);
      logic [15:0] r;
      r = value;
      if (pos == {1'b0, off})
         r[7:0] = b;
      if (pos == ({1'b0, off} + 8'd1))
         r[15:8] = b;
      return r;
   endfunction

endpackage

>>> rtl/sfp_req_if.sv
// Input byte channel.
`timescale 1ns / 1ps

interface sfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/sfp_rsp_if.sv
// Result channel.
`timescale 1ns / 1ps

interface sfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] node_id;
   logic [15:0] battery;
   logic [15:0] temperature;
   logic [15:0] light;

   modport source (output valid, output status, output node_id, output battery,
                   output temperature, output light, input ready);
   modport sink (input valid, input status, input node_id, input battery,
                 input temperature, input light, output ready);
endinterface

>>> rtl/sfp_csr_if.sv
// Configuration write channel.
`timescale 1ns / 1ps

interface sfp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [15:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/sfp_csr_regs.sv
// Configuration register file of the sensor frame parser.
`timescale 1ns / 1ps

module sfp_csr_regs
   import sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [2:0]  wr_index,
   input  logic [15:0] wr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SIGNATURE_OFFSET:   cfg_in.signature_offset = wr_data[6:0];
            CSR_NODE_OFFSET:        cfg_in.node_field_pos   = wr_data[6:0];
            CSR_BATTERY_OFFSET:     cfg_in.battery_offset   = wr_data[6:0];
            CSR_TEMPERATURE_OFFSET: cfg_in.temp_field_pos   = wr_data[6:0];
            CSR_LIGHT_OFFSET:       cfg_in.light_field_pos  = wr_data[6:0];
            CSR_SENSOR_COUNT:       cfg_in.sensor_count     = wr_data;
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signature_offset <= '0;
         cfg_ff.node_field_pos   <= '0;
         cfg_ff.battery_offset   <= '0;
         cfg_ff.temp_field_pos   <= '0;
         cfg_ff.light_field_pos  <= '0;
         cfg_ff.sensor_count     <= 16'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/sfp_parser.sv
// Frame phase tracking, escape handling and field capture, one byte per cycle while accept is high.
`timescale 1ns / 1ps

module sfp_parser
   import sfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = SFP_MAX_FRAME_BYTES
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   localparam logic [7:0] MaxPos = 8'(MAX_FRAME_BYTES);

   phase_type   phase_ff, phase_in;
   escape_type  esc_ff, esc_in;
   logic [7:0]  need_ff, need_in;
   logic [7:0]  done_ff, done_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  sig_ff, sig_in;
   logic [15:0] node_ff, node_in;
   logic [15:0] batt_ff, batt_in;
   logic [15:0] temp_ff, temp_in;
   logic [15:0] light_ff, light_in;

   logic       raw;
   logic [7:0] b_eff;
   logic [7:0] done_inc;

   assign raw      = (phase_ff == PH_START) || (phase_ff == PH_TYPE) || (phase_ff == PH_END);
   assign done_inc = done_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      esc_in    = esc_ff;
      need_in   = need_ff;
      done_in   = done_ff;
      pos_in    = pos_ff;
      sig_in    = sig_ff;
      node_in   = node_ff;
      batt_in   = batt_ff;
      temp_in   = temp_ff;
      light_in  = light_ff;
      b_eff     = rx_byte;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         if (pos_ff >= MaxPos) begin
            // buffer full: drop the byte, rewind, keep phase and escape
            pos_in     = '0;
            res_valid  = 1'b1;
            res.status = ST_OVERFLOW;
         end else if (!raw && (esc_ff == ESC_NONE) &&
                      ((rx_byte == ESC_RAW_BYTE) || (rx_byte == ESC_XOR_BYTE))) begin
            esc_in = (rx_byte == ESC_RAW_BYTE) ? ESC_RAW : ESC_XOR;
         end else begin
            if (!raw) begin
               if (esc_ff == ESC_XOR)
                  b_eff = rx_byte ^ ESC_FLIP_MASK;
               esc_in = ESC_NONE;
            end
            if (pos_ff == {1'b0, cfg.signature_offset})
               sig_in = b_eff;
            node_in  = put_le(node_ff, cfg.node_field_pos, pos_ff, b_eff);
            batt_in  = put_le(batt_ff, cfg.battery_offset, pos_ff, b_eff);
            temp_in  = put_le(temp_ff, cfg.temp_field_pos, pos_ff, b_eff);
            light_in = put_le(light_ff, cfg.light_field_pos, pos_ff, b_eff);
            pos_in   = pos_ff + 8'd1;
            done_in  = done_inc;
            if (done_inc >= need_ff) begin
               done_in = '0;
               unique case (phase_ff)
                  PH_START:   begin phase_in = PH_TYPE;    need_in = 8'd1; end
                  PH_TYPE:    begin phase_in = PH_DEST;    need_in = 8'd2; end
                  PH_DEST:    begin phase_in = PH_AMTYPE;  need_in = 8'd1; end
                  PH_AMTYPE:  begin phase_in = PH_AMGROUP; need_in = 8'd1; end
                  PH_AMGROUP: begin phase_in = PH_LENGTH;  need_in = 8'd1; end
                  PH_LENGTH: begin
                     // empty payload goes straight to the CRC
                     if (b_eff == 8'd0) begin
                        phase_in = PH_CRC;
                        need_in  = 8'd2;
                     end else begin
                        phase_in = PH_PAYLOAD;
                        need_in  = b_eff;
                     end
                  end
                  PH_PAYLOAD: begin phase_in = PH_CRC; need_in = 8'd2; end
                  PH_CRC:     begin phase_in = PH_END; need_in = 8'd1; end
                  default: begin
                     pos_in   = '0;
                     esc_in   = ESC_NONE;
                     phase_in = PH_START;
                     need_in  = 8'd1;
                     if (sig_in == SIGNATURE_BYTE) begin
                        res_valid   = 1'b1;
                        res.node_id = node_in;
                        if ((node_in != 16'd0) && (node_in <= cfg.sensor_count)) begin
                           res.status      = ST_UPDATE;
                           res.battery     = batt_in;
                           res.temperature = temp_in;
                           res.light       = light_in;
                        end else begin
                           res.status = ST_RANGE;
                        end
                     end
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         esc_ff   <= ESC_NONE;
         need_ff  <= 8'd1;
         done_ff  <= '0;
         pos_ff   <= '0;
         sig_ff   <= '0;
         node_ff  <= '0;
         batt_ff  <= '0;
         temp_ff  <= '0;
         light_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         need_ff  <= need_in;
         done_ff  <= done_in;
         pos_ff   <= pos_in;
         sig_ff   <= sig_in;
         node_ff  <= node_in;
         batt_ff  <= batt_in;
         temp_ff  <= temp_in;
         light_ff <= light_in;
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MaxPos)
      else $error("write position beyond frame buffer");

   a_count_below_need: assert property (@(posedge clock) disable iff (reset)
      done_ff < need_ff)
      else $error("phase byte count reached its target without advancing");

   a_no_escape_in_raw: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_START) || (phase_ff == PH_TYPE) || (phase_ff == PH_END))
      |-> (esc_ff == ESC_NONE))
      else $error("escape pending in a raw phase");

   a_overflow_only_full: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.status == ST_OVERFLOW)) |-> (pos_ff >= MaxPos))
      else $error("overflow reported with room in the buffer");

endmodule

>>> rtl/sfp_out_fifo.sv
// Two-entry result buffer that decouples the parser from output back-pressure.
`timescale 1ns / 1ps

module sfp_out_fifo
   import sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   assign pop = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      priority if (pop && push) begin
         if (count_ff == 2'd2) begin
            head_in = tail_ff;
            tail_in = push_data;
         end else begin
            head_in = push_data;
         end
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0)
            head_in = push_data;
         else
            tail_in = push_data;
         count_in = count_ff + 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= '0;
      else
         count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("result pushed into a full buffer");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && push) |=> (out_valid && out_data == $past(push_data)))
      else $error("pushed result not presented");

endmodule

>>> rtl/sensor_frame_parser_top.sv
// Top level of the sensor frame parser.
//
//   channel  role   transaction payload
//   req_     sink   rx_byte (8)
//   rsp_     source status (2), node_id, battery, temperature, light (16 each)
//   csr_     sink   reg_index (3), wdata (16); always ready
//
// One byte per cycle is accepted while req_ready is high; the frame state updates in the cycle of acceptance.
// A result is registered into the result buffer and shown on rsp_ behind any earlier results.
// A two-entry result buffer sets the rate: req_ready drops only when it holds two results.
// Synchronous active-high reset returns the parser to the start phase, offsets to 0,
// sensor_count to 16; no clearing pass is needed.
`timescale 1ns / 1ps

module sensor_frame_parser_top
   import sfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = SFP_MAX_FRAME_BYTES
)
(
   input logic      clock,
   input logic      reset,
   sfp_req_if.sink  req_chan,
   sfp_rsp_if.source rsp_chan,
   sfp_csr_if.sink  csr_chan
);

   cfg_type    cfg;
   logic       req_accept;
   logic       res_valid;
   result_type res;
   logic       buf_full;
   result_type rsp_data;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !buf_full;
   assign req_accept     = req_chan.valid && !buf_full;

   sfp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.reg_index),
      .wr_data  (csr_chan.wdata),
      .cfg      (cfg)
   );

   sfp_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_chan.rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   sfp_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.status      = rsp_data.status;
   assign rsp_chan.node_id     = rsp_data.node_id;
   assign rsp_chan.battery     = rsp_data.battery;
   assign rsp_chan.temperature = rsp_data.temperature;
   assign rsp_chan.light       = rsp_data.light;

endmodule

>>> tb/tb_sensor_frame_parser_top.sv
// Self-checking testbench of the sensor frame parser: byte stimulus, report prediction, checks.
`timescale 1ns / 1ps

import sfp_pkg::*;

class frame_report_scoreboard;
   cfg_type     cfg;
   phase_type   phase;
   escape_type  esc;
   logic [7:0]  need;
   logic [7:0]  done;
   logic [7:0]  wpos;
   logic [7:0]  sig;
   logic [15:0] node;
   logic [15:0] batt;
   logic [15:0] temp;
   logic [15:0] lux;
   result_type  reports_due[$];
   int          errors;

   function new();
      cfg = '0;
      cfg.sensor_count = 16'd16;
      enter_phase(PH_START, 8'd1);
      wpos = '0;
      esc = ESC_NONE;
      sig = '0;
      node = '0;
      batt = '0;
      temp = '0;
      lux = '0;
      errors = 0;
   endfunction

   function void enter_phase(phase_type ph, logic [7:0] n);
      phase = ph;
      need = n;
      done = '0;
   endfunction

   function void set_register(logic [2:0] idx, logic [15:0] data);
      case (csr_index_type'(idx))
         CSR_SIGNATURE_OFFSET:   cfg.signature_offset = data[6:0];
         CSR_NODE_OFFSET:        cfg.node_field_pos = data[6:0];
         CSR_BATTERY_OFFSET:     cfg.battery_offset = data[6:0];
         CSR_TEMPERATURE_OFFSET: cfg.temp_field_pos = data[6:0];
         CSR_LIGHT_OFFSET:       cfg.light_field_pos = data[6:0];
         CSR_SENSOR_COUNT:       cfg.sensor_count = data;
         default: ;
      endcase
   endfunction

   function logic [15:0] capture_le(logic [15:0] cur, logic [6:0] off, logic [7:0] b);
      logic [15:0] r;
      r = cur;
      if (wpos == {1'b0, off})
         r[7:0] = b;
      if (wpos == {1'b0, off} + 8'd1)
         r[15:8] = b;
      return r;
   endfunction

   function bit at_frame_start();
      return phase == PH_START;
   endfunction

   // work out the report, if any, caused by one accepted byte
   function void take_byte(logic [7:0] b);
      logic [7:0] v;
      result_type r;
      bit raw;
      v = b;
      r = '0;
      if (int'(wpos) >= SFP_MAX_FRAME_BYTES) begin
         wpos = '0;
         r.status = ST_OVERFLOW;
         reports_due.push_back(r);
         return;
      end
      raw = (phase == PH_START) || (phase == PH_TYPE) || (phase == PH_END);
      if (!raw) begin
         if (esc == ESC_NONE) begin
            if (v == ESC_RAW_BYTE) begin
               esc = ESC_RAW;
               return;
            end
            if (v == ESC_XOR_BYTE) begin
               esc = ESC_XOR;
               return;
            end
         end else begin
            if (esc == ESC_XOR)
               v = v ^ ESC_FLIP_MASK;
            esc = ESC_NONE;
         end
      end
      if (wpos == {1'b0, cfg.signature_offset})
         sig = v;
      node = capture_le(node, cfg.node_field_pos, v);
      batt = capture_le(batt, cfg.battery_offset, v);
      temp = capture_le(temp, cfg.temp_field_pos, v);
      lux = capture_le(lux, cfg.light_field_pos, v);
      wpos = wpos + 8'd1;
      done = done + 8'd1;
      if (done < need)
         return;
      case (phase)
         PH_START:   enter_phase(PH_TYPE, 8'd1);
         PH_TYPE:    enter_phase(PH_DEST, 8'd2);
         PH_DEST:    enter_phase(PH_AMTYPE, 8'd1);
         PH_AMTYPE:  enter_phase(PH_AMGROUP, 8'd1);
         PH_AMGROUP: enter_phase(PH_LENGTH, 8'd1);
         PH_LENGTH: begin
            if (v == 8'd0)
               enter_phase(PH_CRC, 8'd2);
            else
               enter_phase(PH_PAYLOAD, v);
         end
         PH_PAYLOAD: enter_phase(PH_CRC, 8'd2);
         PH_CRC:     enter_phase(PH_END, 8'd1);
         default: begin
            wpos = '0;
            esc = ESC_NONE;
            enter_phase(PH_START, 8'd1);
            if (sig == SIGNATURE_BYTE) begin
               r.node_id = node;
               if (node != 16'd0 && node <= cfg.sensor_count) begin
                  r.status = ST_UPDATE;
                  r.battery = batt;
                  r.temperature = temp;
                  r.light = lux;
               end else begin
                  r.status = ST_RANGE;
               end
               reports_due.push_back(r);
            end
         end
      endcase
   endfunction

   function void check_report(result_type got);
      result_type want;
      if (reports_due.size() == 0) begin
         $display("%0t: report with none due: status %0d node %h", $time, got.status,
                  got.node_id);
         errors++;
         return;
      end
      want = reports_due.pop_front();
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         errors++;
      end
      if (got.node_id !== want.node_id) begin
         $display("%0t: node_id expected %h actual %h", $time, want.node_id, got.node_id);
         errors++;
      end
      if (got.battery !== want.battery) begin
         $display("%0t: battery expected %h actual %h", $time, want.battery, got.battery);
         errors++;
      end
      if (got.temperature !== want.temperature) begin
         $display("%0t: temperature expected %h actual %h", $time, want.temperature,
                  got.temperature);
         errors++;
      end
      if (got.light !== want.light) begin
         $display("%0t: light expected %h actual %h", $time, want.light, got.light);
         errors++;
      end
   endfunction
endclass

module tb_sensor_frame_parser_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 200;
   // indexes past the last register; writes to them must be ignored
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm = 1'b0;
   int   items_sent = 0;
   int unsigned cycle_count = 0;

   frame_report_scoreboard sb;
   logic [7:0] frame_buf [0:299];
   logic [7:0] directed[$];

   sfp_req_if req_chan ();
   sfp_rsp_if rsp_chan ();
   sfp_csr_if csr_chan ();

   sensor_frame_parser_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sensor_frame_parser_top: mismatch");
         $finish;
      end
   end

   // receiver: stall in random bursts unless calm
   always begin
      @(negedge clock);
      if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      rsp_chan.ready <= 1'b1;
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.status = rsp_chan.status;
         got.node_id = rsp_chan.node_id;
         got.battery = rsp_chan.battery;
         got.temperature = rsp_chan.temperature;
         got.light = rsp_chan.light;
         sb.check_report(got);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.take_byte(b);
      items_sent++;
   endtask

   // escape bytes that need it, and now and then one that does not
   task automatic send_coded(input logic [7:0] b, input bit escapable);
      if (escapable && (b == ESC_RAW_BYTE || b == ESC_XOR_BYTE || $urandom_range(0, 15) == 0)) begin
         if ($urandom_range(0, 1)) begin
            send_byte(ESC_XOR_BYTE);
            send_byte(b ^ ESC_FLIP_MASK);
         end else begin
            send_byte(ESC_RAW_BYTE);
            send_byte(b);
         end
      end else begin
         send_byte(b);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      sb.set_register(idx, data);
   endtask

   // drop the byte stream and wait until every report due has been checked
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.reports_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input logic [6:0] sig_off, input logic [6:0] node_off,
                               input logic [6:0] batt_off, input logic [6:0] temp_off,
                               input logic [6:0] light_off, input logic [15:0] count);
      settle();
      write_reg(CSR_SIGNATURE_OFFSET, {9'($urandom), sig_off});
      write_reg(CSR_NODE_OFFSET, {9'($urandom), node_off});
      write_reg(CSR_BATTERY_OFFSET, {9'($urandom), batt_off});
      write_reg(CSR_TEMPERATURE_OFFSET, {9'($urandom), temp_off});
      write_reg(CSR_LIGHT_OFFSET, {9'($urandom), light_off});
      write_reg(CSR_SENSOR_COUNT, count);
      if ($urandom_range(0, 1))
         write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_node();
      int c;
      c = sb.cfg.sensor_count;
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'(c);
         2: return 16'(c + 1);
         3: return 16'hFFFF;
         default: return 16'($urandom_range(1, (c > 0) ? c : 1));
      endcase
   endfunction

   function automatic void place_field(input logic [6:0] off, input logic [15:0] v,
                                       input int last);
      int o;
      o = off;
      if (o <= last)
         frame_buf[o] = v[7:0];
      if (o + 1 <= last)
         frame_buf[o + 1] = v[15:8];
   endfunction

   // payload long enough to hold every configured field, with a few short and overlong ones
   function automatic int frame_len();
      int maxpos;
      int base;
      maxpos = sb.cfg.signature_offset;
      if (sb.cfg.node_field_pos + 1 > maxpos) maxpos = sb.cfg.node_field_pos + 1;
      if (sb.cfg.battery_offset + 1 > maxpos) maxpos = sb.cfg.battery_offset + 1;
      if (sb.cfg.temp_field_pos + 1 > maxpos) maxpos = sb.cfg.temp_field_pos + 1;
      if (sb.cfg.light_field_pos + 1 > maxpos) maxpos = sb.cfg.light_field_pos + 1;
      base = (maxpos > 9) ? maxpos - 9 : 0;
      case ($urandom_range(0, 15))
         0: return 0;
         1: return $urandom_range(119, 255);
         default: return (base + 6 > 118) ? 118 : base + $urandom_range(0, 6);
      endcase
   endfunction

   // cut below zero sends the whole frame, otherwise only its first cut bytes
   task automatic send_frame(input int len, input bit good, input int cut);
      int last;
      int n;
      int sig_pos;
      last = 9 + len;
      for (int p = 0; p <= last; p++)
         frame_buf[p] = 8'($urandom);
      place_field(sb.cfg.node_field_pos, pick_node(), last);
      place_field(sb.cfg.battery_offset, 16'($urandom), last);
      place_field(sb.cfg.temp_field_pos, 16'($urandom), last);
      place_field(sb.cfg.light_field_pos, 16'($urandom), last);
      sig_pos = sb.cfg.signature_offset;
      if (sig_pos <= last)
         frame_buf[sig_pos] = good ? SIGNATURE_BYTE
                                   : (SIGNATURE_BYTE ^ 8'($urandom_range(1, 255)));
      frame_buf[6] = 8'(len);
      n = (cut < 0) ? last + 1 : cut;
      for (int p = 0; p < n; p++)
         send_coded(frame_buf[p], !(p == 0 || p == 1 || p == last));
   endtask

   task automatic send_noise(input int n);
      int pick;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 2);
         if (pick == 0)
            send_byte(ESC_RAW_BYTE);
         else if (pick == 1)
            send_byte(ESC_XOR_BYTE);
         else
            send_byte(8'($urandom));
      end
   endtask

   // pad with zeros until the parser is back at a start byte
   task automatic close_frame();
      while (!sb.at_frame_start())
         send_byte(8'h00);
   endtask

   task automatic run_traffic(input int quota);
      int first;
      int pick;
      int len;
      first = items_sent;
      while (items_sent - first < quota) begin
         close_frame();
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(frame_len(), 1'b1, -1);
         end else if (pick < 80) begin
            send_frame(frame_len(), 1'b0, -1);
         end else if (pick < 90) begin
            len = frame_len();
            send_frame(len, $urandom_range(0, 1), $urandom_range(1, 9 + len));
            send_noise($urandom_range(0, 6));
         end else begin
            send_noise($urandom_range(1, 20));
         end
      end
      close_frame();
   endtask

   initial begin
      sb = new();
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      csr_chan.valid = 1'b0;
      csr_chan.reg_index = CSR_SIGNATURE_OFFSET;
      csr_chan.wdata = 16'h0000;
      rsp_chan.ready = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset offsets put every field on the start and type bytes
      directed = '{SIGNATURE_BYTE, 8'h00, ESC_XOR_BYTE, 8'h5D, ESC_RAW_BYTE, ESC_RAW_BYTE,
                   8'hFF, 8'h00, 8'h00, ESC_XOR_BYTE, 8'h00, 8'hFF, ESC_RAW_BYTE,
                   SIGNATURE_BYTE, 8'hFF, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h01,
                   ESC_XOR_BYTE, ESC_XOR_BYTE, 8'h00, 8'h00, 8'hFF};
      foreach (directed[i])
         send_byte(directed[i]);

      apply_config(7'd7, 7'd8, 7'd10, 7'd12, 7'd14, 16'd16);
      run_traffic(PHASE_BYTES);
      apply_config(7'd127, 7'd126, 7'd126, 7'd125, 7'd120, 16'hFFFF);
      run_traffic(PHASE_BYTES);
      apply_config(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 16'd0);
      run_traffic(PHASE_BYTES);
      for (int ph = 0; ph < 4; ph++) begin
         if (ph == 3)
            calm = 1'b1;
         apply_config(7'($urandom_range(0, 40)), 7'($urandom_range(0, 40)),
                      7'($urandom_range(0, 40)), 7'($urandom_range(0, 40)),
                      7'($urandom_range(0, 40)),
                      $urandom_range(0, 1) ? 16'($urandom_range(1, 64)) : 16'($urandom));
         run_traffic(PHASE_BYTES);
      end

      settle();
      if (sb.errors == 0 && sb.reports_due.size() == 0)
         $display("sensor_frame_parser_top: match");
      else
         $display("sensor_frame_parser_top: mismatch");
      $finish;
   end

endmodule
